>>> rtl/mcrt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcrt_pkg
// Shared types and constants for the multi-channel reload timer.
// ----------------------------------------------------------------------------
package mcrt_pkg;

  // Fixed port field widths
  localparam int OP_W     = 2;
  localparam int CHAN_W   = 4;
  localparam int TAG_W    = 8;
  localparam int VAL_W    = 16;
  localparam int HANDLE_W = 4;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_CREATE = 2'd0,
    OP_ENABLE = 2'd1,
    OP_SCHED  = 2'd2,
    OP_TICK   = 2'd3
  } op_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RELOAD,
    ST_WALK,
    ST_FLUSH
  } state_t;

endpackage : mcrt_pkg
`default_nettype wire

>>> rtl/multi_channel_reload_timer.sv
`timescale 1ns / 1ps
`default_nettype none
// Reporting: create, disable, schedule and errors report in the cycle after accept;
//   enable first reads the reload value, then reports from ST_RELOAD.
// Acceptance: one command per cycle while idle, except enable (busy in ST_RELOAD) and tick,
//   which walks one entry per cycle in ST_WALK and stays busy through ST_FLUSH.
// Results are single-cycle strobes (no stall). Reset empties the table, clears
//   enables and the ticker and sets lazy_mode; the memories are not cleared.
// ----------------------------------------------------------------------------
// multi_channel_reload_timer
// Table of periodic / one-shot timer channels held in two synchronous
// memories; ticks are processed by a read-modify-write walk over the table.
// ----------------------------------------------------------------------------
module multi_channel_reload_timer #(
  parameter int NUM_CHANNELS = 16,
  parameter int COUNT_WIDTH  = 16
) (
  input  wire                            clk,
  input  wire                            rst_n,
  // configuration
  input  wire                            cfg_we,
  input  wire                            cfg_data,
  // command
  input  wire                            start,
  output logic                           busy,
  input  wire  [mcrt_pkg::OP_W-1:0]      in_op,
  input  wire  [mcrt_pkg::CHAN_W-1:0]    in_channel,
  input  wire  [mcrt_pkg::TAG_W-1:0]     in_task_tag,
  input  wire  [mcrt_pkg::VAL_W-1:0]     in_count_value,
  input  wire                            in_enable,
  // results
  output logic                           out_valid,
  output logic [mcrt_pkg::HANDLE_W-1:0]  out_handle,
  output logic                           out_fired,
  output logic [mcrt_pkg::TAG_W-1:0]     out_fired_task,
  output logic                           out_busy_event,
  output logic                           out_idle_event,
  output logic                           out_error,
  output logic                           out_last
);
  import mcrt_pkg::*;

  localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CNT_W = $clog2(NUM_CHANNELS + 1);
  localparam int ENT_W = TAG_W + COUNT_WIDTH;

  // Control state
  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [NUM_CHANNELS-1:0] on_r, on_nxt;
  logic                    active_r, active_nxt;
  logic                    lazy_r, lazy_nxt;
  logic [CH_W-1:0]         idx_r, idx_nxt;
  logic                    acc_r, acc_nxt;
  logic                    pend_valid_r, pend_valid_nxt;
  logic [CH_W-1:0]         pend_idx_r, pend_idx_nxt;
  logic [TAG_W-1:0]        pend_task_r, pend_task_nxt;

  // Result register
  logic                    out_valid_r, out_valid_nxt;
  logic [HANDLE_W-1:0]     out_handle_r, out_handle_nxt;
  logic                    out_fired_r, out_fired_nxt;
  logic [TAG_W-1:0]        out_task_r, out_task_nxt;
  logic                    out_busy_r, out_busy_nxt;
  logic                    out_idle_r, out_idle_nxt;
  logic                    out_error_r, out_error_nxt;
  logic                    out_last_r, out_last_nxt;

  // Memories: current count, and {task, reload} per channel
  logic [COUNT_WIDTH-1:0]  now_mem [NUM_CHANNELS];
  logic [ENT_W-1:0]        ent_mem [NUM_CHANNELS];
  logic [COUNT_WIDTH-1:0]  now_rdata;
  logic [ENT_W-1:0]        ent_rdata;
  logic                    mem_re;
  logic [CH_W-1:0]         mem_raddr;
  logic                    now_we;
  logic [CH_W-1:0]         now_waddr;
  logic [COUNT_WIDTH-1:0]  now_wdata;
  logic                    ent_we;
  logic [CH_W-1:0]         ent_waddr;
  logic [ENT_W-1:0]        ent_wdata;

  // Read-data fields
  logic [TAG_W-1:0]        rd_task;
  logic [COUNT_WIDTH-1:0]  rd_reload;

  assign rd_task   = ent_rdata[ENT_W-1 -: TAG_W];
  assign rd_reload = ent_rdata[COUNT_WIDTH-1:0];

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_handle     = out_handle_r;
  assign out_fired      = out_fired_r;
  assign out_fired_task = out_task_r;
  assign out_busy_event = out_busy_r;
  assign out_idle_event = out_idle_r;
  assign out_error      = out_error_r;
  assign out_last       = out_last_r;

  // Memory ports
  always_ff @(posedge clk) begin
    if (now_we) begin
      now_mem[now_waddr] <= now_wdata;
    end
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    if (mem_re) begin
      now_rdata <= now_mem[mem_raddr];
      ent_rdata <= ent_mem[mem_raddr];
    end
  end

  // Next state, memory access and result
  always_comb begin
    logic [COUNT_WIDTH-1:0] cv;
    logic [CH_W-1:0]        ch_i;
    logic                   ch_bad;
    logic                   full;
    logic                   cur_on;
    logic [COUNT_WIDTH-1:0] cnt_dec;
    logic                   hit;
    logic                   still_on;
    logic                   walk_last;

    cv        = COUNT_WIDTH'(in_count_value);
    ch_i      = CH_W'(in_channel);
    ch_bad    = (32'(in_channel) >= 32'(count_r));
    full      = (count_r == CNT_W'(NUM_CHANNELS));
    cur_on    = on_r[idx_r];
    cnt_dec   = (now_rdata != '0) ? (now_rdata - COUNT_WIDTH'(1)) : now_rdata;
    hit       = cur_on && (cnt_dec == '0);
    still_on  = cur_on && !(hit && (rd_reload == '0));
    walk_last = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);

    state_nxt      = state_r;
    count_nxt      = count_r;
    on_nxt         = on_r;
    active_nxt     = active_r;
    lazy_nxt       = cfg_we ? cfg_data : lazy_r;
    idx_nxt        = idx_r;
    acc_nxt        = acc_r;
    pend_valid_nxt = pend_valid_r;
    pend_idx_nxt   = pend_idx_r;
    pend_task_nxt  = pend_task_r;

    out_valid_nxt  = 1'b0;
    out_handle_nxt = '0;
    out_fired_nxt  = 1'b0;
    out_task_nxt   = '0;
    out_busy_nxt   = 1'b0;
    out_idle_nxt   = 1'b0;
    out_error_nxt  = 1'b0;
    out_last_nxt   = 1'b0;

    mem_re    = 1'b0;
    mem_raddr = '0;
    now_we    = 1'b0;
    now_waddr = '0;
    now_wdata = '0;
    ent_we    = 1'b0;
    ent_waddr = '0;
    ent_wdata = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (op_t'(in_op))
            OP_CREATE: begin
              out_valid_nxt = 1'b1;
              out_last_nxt  = 1'b1;
              if (full) begin
                out_error_nxt = 1'b1;
              end else begin
                now_we    = 1'b1;
                now_waddr = CH_W'(count_r);
                now_wdata = cv;
                ent_we    = 1'b1;
                ent_waddr = CH_W'(count_r);
                ent_wdata = {in_task_tag, cv};
                on_nxt[CH_W'(count_r)] = (cv != '0) && in_enable;
                count_nxt      = count_r + CNT_W'(1);
                out_handle_nxt = HANDLE_W'(count_r);
                if ((cv != '0) && in_enable) begin
                  out_busy_nxt = lazy_r && !active_r;
                  active_nxt   = 1'b1;
                end
              end
            end
            OP_ENABLE: begin
              if (ch_bad) begin
                out_valid_nxt = 1'b1;
                out_last_nxt  = 1'b1;
                out_error_nxt = 1'b1;
              end else if (in_enable) begin
                // fetch reload value, write it back next cycle
                mem_re    = 1'b1;
                mem_raddr = ch_i;
                idx_nxt   = ch_i;
                state_nxt = ST_RELOAD;
              end else begin
                on_nxt[ch_i]   = 1'b0;
                out_valid_nxt  = 1'b1;
                out_last_nxt   = 1'b1;
                out_handle_nxt = in_channel;
              end
            end
            OP_SCHED: begin
              out_valid_nxt = 1'b1;
              out_last_nxt  = 1'b1;
              if (ch_bad) begin
                out_error_nxt = 1'b1;
              end else begin
                now_we         = 1'b1;
                now_waddr      = ch_i;
                now_wdata      = cv;
                on_nxt[ch_i]   = 1'b1;
                out_handle_nxt = in_channel;
                out_busy_nxt   = lazy_r && !active_r;
                active_nxt     = 1'b1;
              end
            end
            OP_TICK: begin
              acc_nxt        = 1'b0;
              pend_valid_nxt = 1'b0;
              if (lazy_r && !active_r) begin
                // ignored tick
                out_valid_nxt = 1'b1;
                out_last_nxt  = 1'b1;
              end else if (count_r == '0) begin
                state_nxt = ST_FLUSH;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                idx_nxt   = '0;
                state_nxt = ST_WALK;
              end
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_RELOAD: begin
        now_we         = 1'b1;
        now_waddr      = idx_r;
        now_wdata      = rd_reload;
        on_nxt[idx_r]  = 1'b1;
        out_valid_nxt  = 1'b1;
        out_last_nxt   = 1'b1;
        out_handle_nxt = HANDLE_W'(idx_r);
        out_busy_nxt   = lazy_r && !active_r;
        active_nxt     = 1'b1;
        state_nxt      = ST_IDLE;
      end

      ST_WALK: begin
        // count down entry idx_r, reload or stop on expiry
        if (cur_on) begin
          now_we    = 1'b1;
          now_waddr = idx_r;
          now_wdata = (hit && (rd_reload != '0)) ? rd_reload : cnt_dec;
        end
        if (hit && (rd_reload == '0)) begin
          on_nxt[idx_r] = 1'b0;
        end
        acc_nxt = acc_r || still_on;
        // a new expiry releases the one held back
        if (hit) begin
          if (pend_valid_r) begin
            out_valid_nxt  = 1'b1;
            out_fired_nxt  = 1'b1;
            out_handle_nxt = HANDLE_W'(pend_idx_r);
            out_task_nxt   = pend_task_r;
          end
          pend_valid_nxt = 1'b1;
          pend_idx_nxt   = idx_r;
          pend_task_nxt  = rd_task;
        end
        if (walk_last) begin
          state_nxt = ST_FLUSH;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_r + CH_W'(1);
          idx_nxt   = idx_r + CH_W'(1);
        end
      end

      ST_FLUSH: begin
        // final result of the tick carries last and the idle event
        active_nxt    = acc_r;
        out_valid_nxt = 1'b1;
        out_last_nxt  = 1'b1;
        out_idle_nxt  = lazy_r && !acc_r;
        if (pend_valid_r) begin
          out_fired_nxt  = 1'b1;
          out_handle_nxt = HANDLE_W'(pend_idx_r);
          out_task_nxt   = pend_task_r;
        end
        pend_valid_nxt = 1'b0;
        state_nxt      = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      on_r         <= '0;
      active_r     <= 1'b0;
      lazy_r       <= 1'b1;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      on_r         <= on_nxt;
      active_r     <= active_nxt;
      lazy_r       <= lazy_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    acc_r        <= acc_nxt;
    pend_idx_r   <= pend_idx_nxt;
    pend_task_r  <= pend_task_nxt;
    out_handle_r <= out_handle_nxt;
    out_fired_r  <= out_fired_nxt;
    out_task_r   <= out_task_nxt;
    out_busy_r   <= out_busy_nxt;
    out_idle_r   <= out_idle_nxt;
    out_error_r  <= out_error_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Assertions
  a_reload_reports: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RELOAD) |=> (out_valid && out_last && (state_r == ST_IDLE)))
    else $error("reload step did not report a final transaction");

  a_flush_reports: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH) |=> (out_valid && out_last && (state_r == ST_IDLE)))
    else $error("tick did not end with a final transaction");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(count_r) <= NUM_CHANNELS))
    else $error("channel count beyond table size");

  a_idle_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_idle_event) |-> (out_last && !out_error))
    else $error("idle event off the final transaction");

  a_fire_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_fired) |-> (!out_error && !out_busy_event))
    else $error("fired transaction carries error or busy event");

endmodule : multi_channel_reload_timer
`default_nettype wire

>>> dv/tb_multi_channel_reload_timer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_channel_reload_timer
// Self-checking bench for the reload timer table. A behavioral copy of the
// channel table predicts every report of each accepted command; a monitor
// compares each strobed report with the oldest prediction. Directed tests
// cover the corner cases, then random traffic runs in lazy and eager mode.
// ----------------------------------------------------------------------------
module tb_multi_channel_reload_timer;
  import mcrt_pkg::*;

  localparam int NUM_CH = 16;

  // one report of the block
  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic                fired;
    logic [TAG_W-1:0]    fired_task;
    logic                busy_ev;
    logic                idle_ev;
    logic                error;
    logic                last;
  } timer_report_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic                cfg_data;
  logic                start;
  logic                busy;
  logic [OP_W-1:0]     in_op;
  logic [CHAN_W-1:0]   in_channel;
  logic [TAG_W-1:0]    in_task_tag;
  logic [VAL_W-1:0]    in_count_value;
  logic                in_enable;
  logic                out_valid;
  logic [HANDLE_W-1:0] out_handle;
  logic                out_fired;
  logic [TAG_W-1:0]    out_fired_task;
  logic                out_busy_event;
  logic                out_idle_event;
  logic                out_error;
  logic                out_last;

  multi_channel_reload_timer #(
    .NUM_CHANNELS(NUM_CH),
    .COUNT_WIDTH (VAL_W)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .start         (start),
    .busy          (busy),
    .in_op         (in_op),
    .in_channel    (in_channel),
    .in_task_tag   (in_task_tag),
    .in_count_value(in_count_value),
    .in_enable     (in_enable),
    .out_valid     (out_valid),
    .out_handle    (out_handle),
    .out_fired     (out_fired),
    .out_fired_task(out_fired_task),
    .out_busy_event(out_busy_event),
    .out_idle_event(out_idle_event),
    .out_error     (out_error),
    .out_last      (out_last)
  );

  // Shadow copy of the channel table
  logic             tbl_lazy;
  int               tbl_used;
  logic             tbl_on     [NUM_CH];
  logic [VAL_W-1:0] tbl_count  [NUM_CH];
  logic [VAL_W-1:0] tbl_reload [NUM_CH];
  logic [TAG_W-1:0] tbl_tag    [NUM_CH];
  logic             tbl_ticking;

  timer_report_t expected_reports[$];
  int            accept_count;
  int            fail_count;
  int            idle_pct;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic string report_str(timer_report_t r);
    return $sformatf("handle=%0d fired=%0b task=%02h busy=%0b idle=%0b err=%0b last=%0b",
                     r.handle, r.fired, r.fired_task, r.busy_ev, r.idle_ev, r.error,
                     r.last);
  endfunction

  function automatic timer_report_t mk_report(logic [HANDLE_W-1:0] h, logic f,
                                              logic [TAG_W-1:0] t, logic b, logic i,
                                              logic e, logic l);
    timer_report_t r;
    r.handle = h; r.fired = f; r.fired_task = t;
    r.busy_ev = b; r.idle_ev = i; r.error = e; r.last = l;
    return r;
  endfunction

  // Ticker goes active; busy event only reported in lazy mode
  function automatic logic mark_ticking();
    logic ev;
    ev = 1'b0;
    if (!tbl_ticking) begin
      tbl_ticking = 1'b1;
      ev = tbl_lazy;
    end
    return ev;
  endfunction

  // Predict the reports of one accepted command and update the shadow table
  task automatic predict_timer_op(op_t op, logic [CHAN_W-1:0] ch, logic [TAG_W-1:0] tag,
                                  logic [VAL_W-1:0] val, logic en);
    timer_report_t held;
    logic          have_held;
    logic          ev;
    logic          on;
    int            h;
    case (op)
      OP_CREATE: begin
        if (tbl_used >= NUM_CH) begin
          expected_reports.push_back(mk_report(0, 0, 0, 0, 0, 1, 1));
        end else begin
          h = tbl_used;
          on = (val != 0) ? en : 1'b0;
          tbl_on[h] = on;
          tbl_count[h] = val;
          tbl_reload[h] = val;
          tbl_tag[h] = tag;
          tbl_used++;
          ev = on ? mark_ticking() : 1'b0;
          expected_reports.push_back(mk_report(h[HANDLE_W-1:0], 0, 0, ev, 0, 0, 1));
        end
      end
      OP_ENABLE, OP_SCHED: begin
        if (int'(ch) >= tbl_used) begin
          expected_reports.push_back(mk_report(0, 0, 0, 0, 0, 1, 1));
        end else begin
          ev = 1'b0;
          if (op == OP_ENABLE) begin
            tbl_on[ch] = en;
            if (en) begin
              tbl_count[ch] = tbl_reload[ch];
              ev = mark_ticking();
            end
          end else begin
            tbl_count[ch] = val;
            tbl_on[ch] = 1'b1;
            ev = mark_ticking();
          end
          expected_reports.push_back(mk_report(ch, 0, 0, ev, 0, 0, 1));
        end
      end
      default: begin
        if (tbl_lazy && !tbl_ticking) begin
          // tick skipped while idle
          expected_reports.push_back(mk_report(0, 0, 0, 0, 0, 0, 1));
        end else begin
          have_held = 1'b0;
          held = '0;
          tbl_ticking = 1'b0;
          for (int i = 0; i < tbl_used; i++) begin
            if (tbl_on[i]) begin
              if (tbl_count[i] != 0) tbl_count[i]--;
              if (tbl_count[i] == 0) begin
                if (tbl_reload[i] != 0) tbl_count[i] = tbl_reload[i];
                else tbl_on[i] = 1'b0;
                if (have_held) expected_reports.push_back(held);
                held = mk_report(i[HANDLE_W-1:0], 1, tbl_tag[i], 0, 0, 0, 0);
                have_held = 1'b1;
              end
              if (tbl_on[i]) tbl_ticking = 1'b1;
            end
          end
          // idle flag and last marker ride on the final report of the tick
          if (!have_held) held = mk_report(0, 0, 0, 0, 0, 0, 0);
          held.idle_ev = tbl_lazy && !tbl_ticking;
          held.last = 1'b1;
          expected_reports.push_back(held);
        end
      end
    endcase
  endtask

  // Report checker, register shadow and command capture at the rising edge
  always @(posedge clk) begin
    timer_report_t got;
    timer_report_t want;
    if (rst_n) begin
      if (out_valid) begin
        got = mk_report(out_handle, out_fired, out_fired_task, out_busy_event,
                        out_idle_event, out_error, out_last);
        if (expected_reports.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected report: %s", report_str(got));
        end else begin
          want = expected_reports.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("report mismatch at %0t", $realtime);
              $display("  expected %s", report_str(want));
              $display("  actual   %s", report_str(got));
            end
          end
        end
      end
      if (cfg_we) tbl_lazy = cfg_data;
      if (start && !busy) begin
        accept_count++;
        predict_timer_op(op_t'(in_op), in_channel, in_task_tag, in_count_value, in_enable);
      end
    end
  end

  // Drive one command transaction; returns at the falling edge after acceptance
  task automatic send_cmd(op_t op, logic [CHAN_W-1:0] ch, logic [TAG_W-1:0] tag,
                          logic [VAL_W-1:0] val, logic en);
    int n;
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    in_op = op;
    in_channel = ch;
    in_task_tag = tag;
    in_count_value = val;
    in_enable = en;
    n = accept_count;
    do @(negedge clk); while (accept_count == n);
  endtask

  task automatic tick();
    send_cmd(OP_TICK, CHAN_W'($urandom_range(15)), TAG_W'($urandom_range(255)),
             VAL_W'($urandom), 1'($urandom_range(1)));
  endtask

  // Stop issuing and let every outstanding report come back
  task automatic drain_reports();
    start = 1'b0;
    while (expected_reports.size() != 0) @(negedge clk);
    repeat (NUM_CH + 4) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic set_lazy_mode(logic v);
    drain_reports();
    cfg_we = 1'b1;
    cfg_data = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Ticks skipped while idle; commands to channels not yet created
  task automatic test_idle_tick();
    tick();
    send_cmd(OP_ENABLE, 4'd0, 8'h00, 16'h0000, 1'b1);
    send_cmd(OP_SCHED, 4'd15, 8'hff, 16'hffff, 1'b0);
  endtask

  // Create: zero period stays off, largest period, tag extremes
  task automatic test_create();
    send_cmd(OP_CREATE, 4'd15, 8'h00, 16'h0000, 1'b1);
    send_cmd(OP_CREATE, 4'd0, 8'hff, 16'hffff, 1'b0);
    send_cmd(OP_CREATE, 4'd7, 8'h5a, 16'd2, 1'b1);
  endtask

  // Periodic channel fires every period and reloads
  task automatic test_periodic_reload();
    repeat (4) tick();
  endtask

  // Zero count when switched on fires on the next tick, then turns off
  task automatic test_zero_count();
    send_cmd(OP_SCHED, 4'd0, 8'h11, 16'd0, 1'b0);
    tick();
    send_cmd(OP_ENABLE, 4'd0, 8'h22, 16'd9, 1'b1);
    tick();
  endtask

  // Last channel switched off: one more tick reports idle, then ticks skip
  task automatic test_disable_to_idle();
    send_cmd(OP_ENABLE, 4'd2, 8'h00, 16'd0, 1'b0);
    tick();
    tick();
  endtask

  // Eager mode: every tick processed, no busy or idle events
  task automatic test_eager_mode();
    set_lazy_mode(1'b0);
    tick();
    send_cmd(OP_SCHED, 4'd1, 8'h00, 16'd1, 1'b1);
    tick();
    send_cmd(OP_ENABLE, 4'd1, 8'h00, 16'd0, 1'b0);
    set_lazy_mode(1'b1);
  endtask

  // Random mix weighted toward valid channels and short counts
  task automatic test_random_traffic(int count);
    op_t              op;
    logic [CHAN_W-1:0] ch;
    logic [VAL_W-1:0]  val;
    int               r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (r < 15) op = OP_CREATE;
      else if (r < 35) op = OP_ENABLE;
      else if (r < 55) op = OP_SCHED;
      else op = OP_TICK;
      if (tbl_used > 0 && $urandom_range(99) < 85) ch = CHAN_W'($urandom_range(tbl_used - 1));
      else ch = CHAN_W'($urandom_range(15));
      if ($urandom_range(99) < 80) val = VAL_W'($urandom_range(6));
      else val = VAL_W'($urandom);
      send_cmd(op, ch, TAG_W'($urandom_range(255)), val, $urandom_range(99) < 75);
    end
  endtask

  // Fill the table, then one create too many, a schedule of the last channel and ticks
  task automatic test_table_full();
    while (tbl_used < NUM_CH)
      send_cmd(OP_CREATE, CHAN_W'($urandom_range(15)), TAG_W'($urandom_range(255)),
               VAL_W'($urandom_range(1, 4)), 1'b1);
    send_cmd(OP_CREATE, 4'd0, 8'haa, 16'd3, 1'b1);
    send_cmd(OP_SCHED, 4'd15, 8'h00, 16'd1, 1'b1);
    repeat (3) tick();
  endtask

  // Main sequence
  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_data = 1'b1;
    start = 1'b0;
    in_op = OP_CREATE;
    in_channel = '0;
    in_task_tag = '0;
    in_count_value = '0;
    in_enable = 1'b0;
    tbl_lazy = 1'b1;
    tbl_used = 0;
    tbl_ticking = 1'b0;
    for (int i = 0; i < NUM_CH; i++) begin
      tbl_on[i] = 1'b0;
      tbl_count[i] = '0;
      tbl_reload[i] = '0;
      tbl_tag[i] = '0;
    end
    accept_count = 0;
    fail_count = 0;
    idle_pct = 18;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_idle_tick();
    test_create();
    test_periodic_reload();
    test_zero_count();
    test_disable_to_idle();
    test_eager_mode();

    test_random_traffic(20);
    set_lazy_mode(1'b0);
    idle_pct = 0;
    test_random_traffic(20);
    set_lazy_mode(1'b1);
    idle_pct = 18;
    test_random_traffic(20);
    set_lazy_mode(1'b0);
    test_random_traffic(15);
    set_lazy_mode(1'b1);
    test_table_full();

    drain_reports();
    if (fail_count == 0 && expected_reports.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
